// ===== rtl/bsp_pkg.sv =====
package bsp_pkg;

    // Map and brush store geometry
    localparam int MAP_SIDE_MAX   = 256;
    localparam int BRUSH_SIDE_MAX = 32;
    localparam int MAP_CELLS      = MAP_SIDE_MAX * MAP_SIDE_MAX;
    localparam int BRUSH_CELLS    = BRUSH_SIDE_MAX * BRUSH_SIDE_MAX;
    localparam int MAP_AW         = $clog2(MAP_CELLS);
    localparam int BRUSH_AW       = $clog2(BRUSH_CELLS);
    localparam int CLR_CELLS      = (MAP_CELLS > BRUSH_CELLS) ? MAP_CELLS : BRUSH_CELLS;
    localparam int CLR_W          = $clog2(CLR_CELLS);
    localparam int MAP_DIM_W      = $clog2(MAP_SIDE_MAX + 1);
    localparam int BRUSH_DIM_W    = $clog2(BRUSH_SIDE_MAX + 1);
    localparam int BRUSH_IW       = $clog2(BRUSH_SIDE_MAX);

    // Signed width of a map position (cursor plus brush offset)
    localparam int POS_W = 12;

    // Shade arithmetic
    localparam logic [7:0] SHADE_CLEAR = 8'd128;
    localparam int SHADE_MAX   = 255;
    localparam int RATE_TOP    = 19;
    localparam int RATE_PCT    = 5;
    localparam int FULL_PCT    = 100;
    localparam int SCALE_W     = 7;
    localparam int PROD_W      = 15;
    // floor(p / 100) == (p * 5243) >> 19 for every p up to 100 * 255
    localparam int RECIP_100   = 5243;
    localparam int RECIP_SHIFT = 19;
    localparam int QUOT_W      = 28;

    // Configuration register indexes
    localparam logic [2:0] CFG_PAINT_MODE   = 3'd0;
    localparam logic [2:0] CFG_RATE_STEP    = 3'd1;
    localparam logic [2:0] CFG_MAP_WIDTH    = 3'd2;
    localparam logic [2:0] CFG_MAP_HEIGHT   = 3'd3;
    localparam logic [2:0] CFG_BRUSH_WIDTH  = 3'd4;
    localparam logic [2:0] CFG_BRUSH_HEIGHT = 3'd5;

    typedef enum logic [1:0] {
        KIND_LOAD,
        KIND_PAINT,
        KIND_PENUP,
        KIND_READ
    } t_kind;

    typedef enum logic [1:0] {
        MODE_PAINT,
        MODE_LIGHTEN,
        MODE_DARKEN,
        MODE_HOLD
    } t_mode;

    function automatic logic in_map(
        input logic signed [POS_W-1:0] x,
        input logic signed [POS_W-1:0] y,
        input logic [MAP_DIM_W-1:0]    w,
        input logic [MAP_DIM_W-1:0]    h
    );
        return !x[POS_W-1] && !y[POS_W-1]
            && (x < $signed(POS_W'(w))) && (y < $signed(POS_W'(h)));
    endfunction

    function automatic logic [MAP_AW-1:0] cell_index(
        input logic signed [POS_W-1:0] x,
        input logic signed [POS_W-1:0] y
    );
        return MAP_AW'(y) * MAP_AW'(MAP_SIDE_MAX) + MAP_AW'(x);
    endfunction

endpackage

// ===== rtl/brush_stamp_painter.sv =====
// Channel   | Direction | Handshake           | Payload
// ----------+-----------+---------------------+---------------------------------------------
// input     | in        | i_valid / o_ready   | i_kind, i_cursor_x, i_cursor_y,
//           |           |                     | i_brush_addr, i_brush_value
// result    | out       | o_valid / i_ready   | o_cell_value, o_done_res
// config    | in        | i_cfg_we (no wait)  | i_cfg_idx, i_cfg_data
//
// Sequencing: one transaction at a time. Load and pen-up go straight to the done state, a read
//   passes through the read and read-wait states, a paint walks the brush one brush pixel a cycle
//   through a 3-stage read-modify-write pipe on the map memory and then drains (the drain ends
//   early when the last pixels are skipped); a repeated cursor goes straight to the done state.
// Reset: synchronous, active low. A clearing pass then sweeps the map memory (the brush store
//   is cleared in the same sweep); no input is taken until it ends.
// Stalls: a finished result waits in the done state until the output register is free; the next
//   transaction is taken once the result has moved into the output register.
module brush_stamp_painter (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [1:0]        i_kind,
    input  logic signed [9:0] i_cursor_x,
    input  logic signed [9:0] i_cursor_y,
    input  logic [9:0]        i_brush_addr,
    input  logic [7:0]        i_brush_value,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [7:0]        o_cell_value,
    output logic              o_done_res,
    input  logic              i_cfg_we,
    input  logic [2:0]        i_cfg_idx,
    input  logic [8:0]        i_cfg_data
);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_RWAIT,
        ST_WALK,
        ST_DRAIN,
        ST_DONE
    } t_state;

    t_state r_state;

    // Configuration registers
    logic [1:0] r_paint_mode;
    logic [4:0] r_rate_step;
    logic [8:0] r_map_width;
    logic [8:0] r_map_height;
    logic [5:0] r_brush_width;
    logic [5:0] r_brush_height;

    // Effective (clamped) settings
    logic [bsp_pkg::MAP_DIM_W-1:0]   map_w;
    logic [bsp_pkg::MAP_DIM_W-1:0]   map_h;
    logic [bsp_pkg::BRUSH_DIM_W-1:0] brush_w;
    logic [bsp_pkg::BRUSH_DIM_W-1:0] brush_h;
    logic [bsp_pkg::BRUSH_DIM_W-1:0] brush_w_m1;
    logic [bsp_pkg::BRUSH_DIM_W-1:0] brush_h_m1;
    logic [4:0]                      rate_c;
    logic [bsp_pkg::SCALE_W-1:0]     scale;

    // Control and item registers
    logic                           accept;
    logic [bsp_pkg::CLR_W-1:0]      r_clr;
    logic signed [9:0]              r_last_x;
    logic signed [9:0]              r_last_y;
    logic signed [9:0]              r_cx;
    logic signed [9:0]              r_cy;
    logic signed [bsp_pkg::POS_W-1:0] r_ox;
    logic signed [bsp_pkg::POS_W-1:0] r_oy;
    logic [bsp_pkg::BRUSH_IW-1:0]   r_col;
    logic [bsp_pkg::BRUSH_IW-1:0]   r_row;
    logic [bsp_pkg::BRUSH_AW-1:0]   r_baddr;
    logic [7:0]                     r_res;
    logic                           r_o_valid;
    logic [7:0]                     r_o_cell;

    // Pipeline registers
    logic                           r_s1_v;
    logic                           r_s1_in;
    logic [bsp_pkg::MAP_AW-1:0]     r_s1_cell;
    logic                           r_s2_v;
    logic [bsp_pkg::MAP_AW-1:0]     r_s2_cell;
    logic [bsp_pkg::PROD_W-1:0]     r_s2_prod;
    logic                           r_s3_v;
    logic [bsp_pkg::MAP_AW-1:0]     r_s3_cell;
    logic [7:0]                     r_s3_cur;
    logic [bsp_pkg::QUOT_W-1:0]     r_s3_q;

    // Walk and read addressing
    logic signed [bsp_pkg::POS_W-1:0] px;
    logic signed [bsp_pkg::POS_W-1:0] py;
    logic signed [bsp_pkg::POS_W-1:0] rd_x;
    logic signed [bsp_pkg::POS_W-1:0] rd_y;
    logic                             walk_in;
    logic [bsp_pkg::MAP_AW-1:0]       walk_cell;
    logic                             read_in;
    logic [bsp_pkg::MAP_AW-1:0]       read_cell;

    // Shade update
    logic [7:0]        inc;
    logic signed [9:0] sum;
    logic [7:0]        new_shade;

    // Memories
    logic [7:0] r_map_mem [bsp_pkg::MAP_CELLS];
    logic [7:0] r_brush_mem [bsp_pkg::BRUSH_CELLS];
    logic [7:0] r_map_q;
    logic [7:0] r_brush_q;
    logic                          map_we;
    logic [bsp_pkg::MAP_AW-1:0]    map_wa;
    logic [7:0]                    map_wd;
    logic [bsp_pkg::MAP_AW-1:0]    map_ra;
    logic                          brush_we;
    logic [bsp_pkg::BRUSH_AW-1:0]  brush_wa;
    logic [7:0]                    brush_wd;
    logic                          clr_last;
    logic                          out_free;

    assign o_ready      = (r_state == ST_IDLE);
    assign accept       = i_valid && o_ready;
    assign o_valid      = r_o_valid;
    assign o_cell_value = r_o_cell;
    assign o_done_res   = 1'b1;
    assign out_free     = !r_o_valid || i_ready;
    assign clr_last     = (r_clr == bsp_pkg::CLR_W'(bsp_pkg::CLR_CELLS - 1));

    // ---------------------------------------------------------------
    // Configuration port: the user writes it only while idle (not enforced); no read-back
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_paint_mode   <= 2'd0;
            r_rate_step    <= 5'd0;
            r_map_width    <= 9'd256;
            r_map_height   <= 9'd256;
            r_brush_width  <= 6'd1;
            r_brush_height <= 6'd1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                bsp_pkg::CFG_PAINT_MODE:   r_paint_mode   <= i_cfg_data[1:0];
                bsp_pkg::CFG_RATE_STEP:    r_rate_step    <= i_cfg_data[4:0];
                bsp_pkg::CFG_MAP_WIDTH:    r_map_width    <= i_cfg_data;
                bsp_pkg::CFG_MAP_HEIGHT:   r_map_height   <= i_cfg_data;
                bsp_pkg::CFG_BRUSH_WIDTH:  r_brush_width  <= i_cfg_data[5:0];
                bsp_pkg::CFG_BRUSH_HEIGHT: r_brush_height <= i_cfg_data[5:0];
                default: ;
            endcase
        end
    end

    // Clamp sizes into their legal ranges; a zero size acts as one
    always_comb begin
        if (r_map_width == '0) begin
            map_w = bsp_pkg::MAP_DIM_W'(1);
        end else if (32'(r_map_width) > 32'(bsp_pkg::MAP_SIDE_MAX)) begin
            map_w = bsp_pkg::MAP_DIM_W'(bsp_pkg::MAP_SIDE_MAX);
        end else begin
            map_w = bsp_pkg::MAP_DIM_W'(r_map_width);
        end
        if (r_map_height == '0) begin
            map_h = bsp_pkg::MAP_DIM_W'(1);
        end else if (32'(r_map_height) > 32'(bsp_pkg::MAP_SIDE_MAX)) begin
            map_h = bsp_pkg::MAP_DIM_W'(bsp_pkg::MAP_SIDE_MAX);
        end else begin
            map_h = bsp_pkg::MAP_DIM_W'(r_map_height);
        end
        if (r_brush_width == '0) begin
            brush_w = bsp_pkg::BRUSH_DIM_W'(1);
        end else if (32'(r_brush_width) > 32'(bsp_pkg::BRUSH_SIDE_MAX)) begin
            brush_w = bsp_pkg::BRUSH_DIM_W'(bsp_pkg::BRUSH_SIDE_MAX);
        end else begin
            brush_w = bsp_pkg::BRUSH_DIM_W'(r_brush_width);
        end
        if (r_brush_height == '0) begin
            brush_h = bsp_pkg::BRUSH_DIM_W'(1);
        end else if (32'(r_brush_height) > 32'(bsp_pkg::BRUSH_SIDE_MAX)) begin
            brush_h = bsp_pkg::BRUSH_DIM_W'(bsp_pkg::BRUSH_SIDE_MAX);
        end else begin
            brush_h = bsp_pkg::BRUSH_DIM_W'(r_brush_height);
        end
        brush_w_m1 = brush_w - bsp_pkg::BRUSH_DIM_W'(1);
        brush_h_m1 = brush_h - bsp_pkg::BRUSH_DIM_W'(1);
        // Strength saturates at the weakest step
        rate_c = (r_rate_step > 5'(bsp_pkg::RATE_TOP)) ? 5'(bsp_pkg::RATE_TOP) : r_rate_step;
        scale  = bsp_pkg::SCALE_W'(bsp_pkg::FULL_PCT)
               - bsp_pkg::SCALE_W'(rate_c) * bsp_pkg::SCALE_W'(bsp_pkg::RATE_PCT);
    end

    // ---------------------------------------------------------------
    // Addressing: walker position and read-item cell
    // ---------------------------------------------------------------
    always_comb begin
        px        = r_ox + $signed(bsp_pkg::POS_W'(r_col));
        py        = r_oy + $signed(bsp_pkg::POS_W'(r_row));
        walk_in   = bsp_pkg::in_map(px, py, map_w, map_h);
        walk_cell = bsp_pkg::cell_index(px, py);
        rd_x      = bsp_pkg::POS_W'(r_cx);
        rd_y      = bsp_pkg::POS_W'(r_cy);
        read_in   = bsp_pkg::in_map(rd_x, rd_y, map_w, map_h);
        read_cell = bsp_pkg::cell_index(rd_x, rd_y);
    end

    // ---------------------------------------------------------------
    // Last stage: scale, combine with the current shade, clamp
    // ---------------------------------------------------------------
    always_comb begin
        inc = r_s3_q[bsp_pkg::RECIP_SHIFT +: 8];
        case (bsp_pkg::t_mode'(r_paint_mode))
            bsp_pkg::MODE_PAINT:   sum = $signed({2'b00, inc});
            bsp_pkg::MODE_LIGHTEN: sum = $signed({2'b00, r_s3_cur}) + $signed({2'b00, inc});
            bsp_pkg::MODE_DARKEN:  sum = $signed({2'b00, r_s3_cur}) - $signed({2'b00, inc});
            default:               sum = $signed({2'b00, r_s3_cur});
        endcase
        if (sum < 0) begin
            new_shade = 8'd0;
        end else if (sum > 10'sd255) begin
            new_shade = 8'(bsp_pkg::SHADE_MAX);
        end else begin
            new_shade = sum[7:0];
        end
    end

    // ---------------------------------------------------------------
    // Memory port muxing. Within one stamp every pixel hits a distinct
    // cell, so the write in the last stage never meets a pending read;
    // items are serialized, so nothing overlaps across items either.
    // ---------------------------------------------------------------
    always_comb begin
        if (r_state == ST_CLEAR) begin
            map_we = (32'(r_clr) < 32'(bsp_pkg::MAP_CELLS));
            map_wa = r_clr[bsp_pkg::MAP_AW-1:0];
            map_wd = bsp_pkg::SHADE_CLEAR;
        end else begin
            map_we = r_s3_v;
            map_wa = r_s3_cell;
            map_wd = new_shade;
        end
        map_ra = (r_state == ST_READ) ? read_cell : r_s1_cell;

        if (r_state == ST_CLEAR) begin
            brush_we = (32'(r_clr) < 32'(bsp_pkg::BRUSH_CELLS));
            brush_wa = r_clr[bsp_pkg::BRUSH_AW-1:0];
            brush_wd = 8'd0;
        end else begin
            // Drop loads whose address lies beyond the store
            brush_we = accept && (bsp_pkg::t_kind'(i_kind) == bsp_pkg::KIND_LOAD)
                    && (32'(i_brush_addr) < 32'(bsp_pkg::BRUSH_CELLS));
            brush_wa = bsp_pkg::BRUSH_AW'(i_brush_addr);
            brush_wd = i_brush_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (map_we) begin
            r_map_mem[map_wa] <= map_wd;
        end
        r_map_q <= r_map_mem[map_ra];
    end

    always_ff @(posedge i_clk) begin
        if (brush_we) begin
            r_brush_mem[brush_wa] <= brush_wd;
        end
        r_brush_q <= r_brush_mem[r_baddr];
    end

    // ---------------------------------------------------------------
    // Pipeline payload: stage 1 holds the cell while the brush pixel
    // arrives, stage 2 the product while the shade arrives, stage 3
    // the scaled quotient for the write-back.
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cx <= i_cursor_x;
            r_cy <= i_cursor_y;
            r_ox <= bsp_pkg::POS_W'(i_cursor_x) - bsp_pkg::POS_W'(brush_w >> 1);
            r_oy <= bsp_pkg::POS_W'(i_cursor_y) - bsp_pkg::POS_W'(brush_h >> 1);
        end
        r_s1_in   <= walk_in;
        r_s1_cell <= walk_cell;
        r_s2_cell <= r_s1_cell;
        r_s2_prod <= bsp_pkg::PROD_W'(scale) * bsp_pkg::PROD_W'(r_brush_q);
        r_s3_cell <= r_s2_cell;
        r_s3_cur  <= r_map_q;
        r_s3_q    <= bsp_pkg::QUOT_W'(r_s2_prod) * bsp_pkg::QUOT_W'(bsp_pkg::RECIP_100);
    end

    // ---------------------------------------------------------------
    // Sequencer: state, last cursor, walker, stage valids, result slot
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLEAR;
            r_clr     <= '0;
            r_last_x  <= '1;
            r_last_y  <= '1;
            r_col     <= '0;
            r_row     <= '0;
            r_baddr   <= '0;
            r_res     <= '0;
            r_s1_v    <= 1'b0;
            r_s2_v    <= 1'b0;
            r_s3_v    <= 1'b0;
            r_o_valid <= 1'b0;
            r_o_cell  <= '0;
        end else begin
            // Load the result slot from the done state, else free it once taken
            if (r_state == ST_DONE && out_free) begin
                r_o_valid <= 1'b1;
                r_o_cell  <= r_res;
            end else if (r_o_valid && i_ready) begin
                r_o_valid <= 1'b0;
            end
            // One brush pixel enters the pipe each walk cycle
            r_s1_v <= (r_state == ST_WALK);
            // Transparent pixels and pixels off the map leave the pipe here
            r_s2_v <= r_s1_v && r_s1_in && (r_brush_q != 8'd0);
            r_s3_v <= r_s2_v;

            case (r_state)
                ST_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (clr_last) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (i_valid) begin
                        r_res <= 8'd0;
                        case (bsp_pkg::t_kind'(i_kind))
                            bsp_pkg::KIND_PAINT: begin
                                if (i_cursor_x == r_last_x && i_cursor_y == r_last_y) begin
                                    r_state <= ST_DONE;
                                end else begin
                                    r_last_x <= i_cursor_x;
                                    r_last_y <= i_cursor_y;
                                    r_col    <= '0;
                                    r_row    <= '0;
                                    r_baddr  <= '0;
                                    r_state  <= ST_WALK;
                                end
                            end
                            bsp_pkg::KIND_PENUP: begin
                                r_last_x <= '1;
                                r_last_y <= '1;
                                r_state  <= ST_DONE;
                            end
                            bsp_pkg::KIND_READ: r_state <= ST_READ;
                            default:            r_state <= ST_DONE;
                        endcase
                    end
                end
                ST_READ: r_state <= ST_RWAIT;
                ST_RWAIT: begin
                    r_res   <= read_in ? r_map_q : 8'd0;
                    r_state <= ST_DONE;
                end
                ST_WALK: begin
                    // Issue one brush pixel per cycle in row-major order
                    r_baddr <= r_baddr + 1'b1;
                    if (r_col == brush_w_m1[bsp_pkg::BRUSH_IW-1:0]) begin
                        r_col <= '0;
                        r_row <= r_row + 1'b1;
                        if (r_row == brush_h_m1[bsp_pkg::BRUSH_IW-1:0]) begin
                            r_state <= ST_DRAIN;
                        end
                    end else begin
                        r_col <= r_col + 1'b1;
                    end
                end
                ST_DRAIN: begin
                    if (!r_s1_v && !r_s2_v && !r_s3_v) begin
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    // Hold the result until the output slot is free
                    if (out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

endmodule

// ===== sim/tb_brush_stamp_painter.sv =====
module tb_brush_stamp_painter;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD   = 8;
    localparam int RESET_CYCLES = 6;
    // Slowest legal run: clearing sweep plus ~540 transactions, each a full 32x32
    // stamp with the longest gap and stall on both sides; taken about 5x over.
    localparam int LIMIT_CYCLES = 3_000_000;
    localparam int TAIL_CYCLES  = 40;
    localparam int N_SETTINGS   = 9;

    // One input transaction, as presented on the payload ports
    typedef struct {
        bsp_pkg::t_kind     kind;
        logic signed [9:0]  cx;
        logic signed [9:0]  cy;
        logic [9:0]         addr;
        logic [7:0]         val;
    } t_stroke;

    // One result transaction
    typedef struct {
        logic [7:0] cell_value;
        logic       done;
    } t_shade_out;

    // DUT ports; the inputs are all known from time zero
    logic              i_clk         = 1'b0;
    logic              i_rst_n       = 1'b0;
    logic              i_valid       = 1'b0;
    logic              o_ready;
    logic [1:0]        i_kind        = bsp_pkg::KIND_LOAD;
    logic signed [9:0] i_cursor_x    = '0;
    logic signed [9:0] i_cursor_y    = '0;
    logic [9:0]        i_brush_addr  = '0;
    logic [7:0]        i_brush_value = '0;
    logic              o_valid;
    logic              i_ready       = 1'b0;
    logic [7:0]        o_cell_value;
    logic              o_done_res;
    logic              i_cfg_we      = 1'b0;
    logic [2:0]        i_cfg_idx     = bsp_pkg::CFG_PAINT_MODE;
    logic [8:0]        i_cfg_data    = '0;

    // Shadow copy of the block: map, brush, last cursor and register file
    logic [7:0] shade_mem [bsp_pkg::MAP_CELLS];
    logic [7:0] brush_mem [bsp_pkg::BRUSH_CELLS];
    int         last_cx;
    int         last_cy;
    logic [1:0] mode_reg;
    logic [4:0] rate_reg;
    logic [8:0] map_w_reg;
    logic [8:0] map_h_reg;
    logic [5:0] brush_w_reg;
    logic [5:0] brush_h_reg;

    t_stroke    stroke_queue [$];   // transactions waiting for the driver
    t_shade_out shades_due   [$];   // predicted results, oldest first

    t_stroke    cur_stroke;
    t_stroke    next_stroke;
    t_shade_out due_shade;

    int          strokes_queued = 0;
    int          strokes_taken  = 0;
    int          results_seen   = 0;
    int          mismatches     = 0;
    int          stamps_applied = 0;
    int          kind_tally [4] = '{0, 0, 0, 0};
    int          gap_left       = 0;
    int          stall_left     = 0;
    bit          calm           = 1'b0;   // no idling on either side when set
    int unsigned cycle_count    = 0;

    brush_stamp_painter u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_kind        (i_kind),
        .i_cursor_x    (i_cursor_x),
        .i_cursor_y    (i_cursor_y),
        .i_brush_addr  (i_brush_addr),
        .i_brush_value (i_brush_value),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_cell_value  (o_cell_value),
        .o_done_res    (o_done_res),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    function automatic int clamp_int(input int v, input int lo, input int hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    // Advance the shadow state by one transaction and return the shade it must produce.
    function automatic t_shade_out apply_stroke(input t_stroke s);
        t_shade_out res;
        int mw, mh, bw, bh, scale, ox, oy, cx, cy, px, py, pix, inc, cur, val;
        mw    = clamp_int(int'(map_w_reg), 1, bsp_pkg::MAP_SIDE_MAX);
        mh    = clamp_int(int'(map_h_reg), 1, bsp_pkg::MAP_SIDE_MAX);
        bw    = clamp_int(int'(brush_w_reg), 1, bsp_pkg::BRUSH_SIDE_MAX);
        bh    = clamp_int(int'(brush_h_reg), 1, bsp_pkg::BRUSH_SIDE_MAX);
        // A rate above the top step acts as the top step
        scale = bsp_pkg::FULL_PCT
              - bsp_pkg::RATE_PCT * clamp_int(int'(rate_reg), 0, bsp_pkg::RATE_TOP);
        cx    = int'(s.cx);
        cy    = int'(s.cy);
        res.cell_value = '0;
        res.done       = 1'b1;
        kind_tally[s.kind]++;
        case (s.kind)
            bsp_pkg::KIND_LOAD: begin
                if (int'(s.addr) < bsp_pkg::BRUSH_CELLS)
                    brush_mem[s.addr] = s.val;
            end
            bsp_pkg::KIND_PAINT: begin
                // Same cursor as the previous stamp: nothing at all happens
                if (cx != last_cx || cy != last_cy) begin
                    last_cx = cx;
                    last_cy = cy;
                    stamps_applied++;
                    ox = cx - bw / 2;
                    oy = cy - bh / 2;
                    for (int r = 0; r < bh; r++) begin
                        for (int c = 0; c < bw; c++) begin
                            pix = int'(brush_mem[bsp_pkg::BRUSH_AW'(r * bw + c)]);
                            px  = ox + c;
                            py  = oy + r;
                            if (pix != 0 && px >= 0 && px < mw && py >= 0 && py < mh) begin
                                inc = (scale * pix) / bsp_pkg::FULL_PCT;
                                cur = int'(shade_mem[bsp_pkg::MAP_AW'(
                                          py * bsp_pkg::MAP_SIDE_MAX + px)]);
                                case (bsp_pkg::t_mode'(mode_reg))
                                    bsp_pkg::MODE_PAINT:   val = inc;
                                    bsp_pkg::MODE_LIGHTEN: val = cur + inc;
                                    bsp_pkg::MODE_DARKEN:  val = cur - inc;
                                    default:               val = cur;
                                endcase
                                shade_mem[bsp_pkg::MAP_AW'(py * bsp_pkg::MAP_SIDE_MAX + px)] =
                                    8'(clamp_int(val, 0, bsp_pkg::SHADE_MAX));
                            end
                        end
                    end
                end
            end
            bsp_pkg::KIND_PENUP: begin
                last_cx = -1;
                last_cy = -1;
            end
            default: begin
                // Reads outside the map in use return zero
                if (cx >= 0 && cx < mw && cy >= 0 && cy < mh)
                    res.cell_value =
                        shade_mem[bsp_pkg::MAP_AW'(cy * bsp_pkg::MAP_SIDE_MAX + cx)];
            end
        endcase
        return res;
    endfunction

    // Driver: hold the payload until the transaction is taken, then advance the queue.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid  <= 1'b0;
            gap_left <= 0;
        end else begin
            if (i_valid && o_ready) begin
                shades_due.push_back(apply_stroke(cur_stroke));
                strokes_taken <= strokes_taken + 1;
            end
            if (!i_valid || o_ready) begin
                if (gap_left != 0) begin
                    // Idle burst in progress: drop valid and count down
                    gap_left <= gap_left - 1;
                    i_valid  <= 1'b0;
                end else if (stroke_queue.size() != 0) begin
                    next_stroke    = stroke_queue.pop_front();
                    cur_stroke    <= next_stroke;
                    i_kind        <= next_stroke.kind;
                    i_cursor_x    <= next_stroke.cx;
                    i_cursor_y    <= next_stroke.cy;
                    i_brush_addr  <= next_stroke.addr;
                    i_brush_value <= next_stroke.val;
                    i_valid       <= 1'b1;
                    // Schedule an idle burst after this transaction now and then
                    if (!calm && $urandom_range(0, 7) == 0)
                        gap_left <= $urandom_range(1, 13);
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare each result transaction with the oldest prediction.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready    <= 1'b0;
            stall_left <= 0;
        end else begin
            if (o_valid && i_ready) begin
                results_seen <= results_seen + 1;
                if (shades_due.size() == 0) begin
                    $display("%0t: result with nothing expected, expected none, %s %0d",
                             $time, "actual cell_value", o_cell_value);
                    mismatches++;
                end else begin
                    due_shade = shades_due.pop_front();
                    if (o_cell_value !== due_shade.cell_value) begin
                        $display("%0t: cell_value mismatch, expected %0d, actual %0d",
                                 $time, due_shade.cell_value, o_cell_value);
                        mismatches++;
                    end
                    if (o_done_res !== due_shade.done) begin
                        $display("%0t: done_res mismatch, expected %0b, actual %0b",
                                 $time, due_shade.done, o_done_res);
                        mismatches++;
                    end
                end
            end
            // Random stall bursts: ready drops now and stays low while the countdown runs
            if (stall_left != 0) begin
                stall_left <= stall_left - 1;
                i_ready    <= 1'b0;
            end else if (!calm && $urandom_range(0, 9) == 0) begin
                stall_left <= $urandom_range(0, 12);
                i_ready    <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic queue_stroke(input bsp_pkg::t_kind k, input int x, input int y,
                                input int a, input int v);
        t_stroke s;
        s.kind = k;
        // Fields the kind does not use still get random content
        s.cx   = (k == bsp_pkg::KIND_PAINT || k == bsp_pkg::KIND_READ) ? 10'(x) : 10'($urandom);
        s.cy   = (k == bsp_pkg::KIND_PAINT || k == bsp_pkg::KIND_READ) ? 10'(y) : 10'($urandom);
        s.addr = (k == bsp_pkg::KIND_LOAD) ? 10'(a) : 10'($urandom);
        s.val  = (k == bsp_pkg::KIND_LOAD) ? 8'(v) : 8'($urandom);
        stroke_queue.push_back(s);
        strokes_queued++;
    endtask

    // Register writes land back to back; the caller drops the enable afterwards.
    task automatic cfg_write(input logic [2:0] idx, input int value);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= 9'(value);
        case (idx)
            bsp_pkg::CFG_PAINT_MODE:   mode_reg    = 2'(value);
            bsp_pkg::CFG_RATE_STEP:    rate_reg    = 5'(value);
            bsp_pkg::CFG_MAP_WIDTH:    map_w_reg   = 9'(value);
            bsp_pkg::CFG_MAP_HEIGHT:   map_h_reg   = 9'(value);
            bsp_pkg::CFG_BRUSH_WIDTH:  brush_w_reg = 6'(value);
            bsp_pkg::CFG_BRUSH_HEIGHT: brush_h_reg = 6'(value);
            default: ;
        endcase
    endtask

    task automatic apply_setting(input int mode, input int rate, input int mw, input int mh,
                                 input int bw, input int bh);
        cfg_write(bsp_pkg::CFG_PAINT_MODE, mode);
        cfg_write(bsp_pkg::CFG_RATE_STEP, rate);
        cfg_write(bsp_pkg::CFG_MAP_WIDTH, mw);
        cfg_write(bsp_pkg::CFG_MAP_HEIGHT, mh);
        cfg_write(bsp_pkg::CFG_BRUSH_WIDTH, bw);
        cfg_write(bsp_pkg::CFG_BRUSH_HEIGHT, bh);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Hold until every queued transaction is taken and every result has come back.
    task automatic wait_drained();
        do @(negedge i_clk);
        while (strokes_taken != strokes_queued || results_seen != strokes_taken);
    endtask

    // Mostly well-formed strokes: brush loads, stamps on the map, reads around the
    // latest stamp; the rest is off-map cursors, repeats, pen-ups and full-range noise.
    task automatic queue_random_phase(input int count);
        int mw, mh, bw, bh, ax, ay, roll, n, base, x, y, a, v;
        mw = clamp_int(int'(map_w_reg), 1, bsp_pkg::MAP_SIDE_MAX);
        mh = clamp_int(int'(map_h_reg), 1, bsp_pkg::MAP_SIDE_MAX);
        bw = clamp_int(int'(brush_w_reg), 1, bsp_pkg::BRUSH_SIDE_MAX);
        bh = clamp_int(int'(brush_h_reg), 1, bsp_pkg::BRUSH_SIDE_MAX);
        ax = $urandom_range(0, mw - 1);
        ay = $urandom_range(0, mh - 1);
        base = strokes_queued;
        n    = 0;
        while (n < count) begin
            roll = (n < 10) ? 50 : $urandom_range(0, 99);
            if (roll < 30) begin
                case ($urandom_range(0, 9))
                    0: begin
                        ax = int'($urandom_range(0, 1023)) - 512;
                        ay = int'($urandom_range(0, 1023)) - 512;
                    end
                    1, 2: begin
                        ax = int'($urandom_range(0, mw + 2 * bw)) - bw;
                        ay = int'($urandom_range(0, mh + 2 * bh)) - bh;
                    end
                    default: begin
                        ax = $urandom_range(0, mw - 1);
                        ay = $urandom_range(0, mh - 1);
                    end
                endcase
                queue_stroke(bsp_pkg::KIND_PAINT, ax, ay, 0, 0);
            end else if (roll < 37) begin
                queue_stroke(bsp_pkg::KIND_PAINT, ax, ay, 0, 0);
            end else if (roll < 45) begin
                queue_stroke(bsp_pkg::KIND_PENUP, 0, 0, 0, 0);
                // Restamp the same spot to pile up toward the clamp, or hit the cleared cursor
                case ($urandom_range(0, 3))
                    0:       queue_stroke(bsp_pkg::KIND_PAINT, -1, -1, 0, 0);
                    1, 2:    queue_stroke(bsp_pkg::KIND_PAINT, ax, ay, 0, 0);
                    default: ;
                endcase
            end else if (roll < 60) begin
                a = ($urandom_range(0, 9) < 7) ? $urandom_range(0, bw * bh - 1)
                                               : $urandom_range(0, bsp_pkg::BRUSH_CELLS - 1);
                case ($urandom_range(0, 7))
                    0, 1:    v = 0;
                    2:       v = 255;
                    default: v = $urandom_range(0, 255);
                endcase
                queue_stroke(bsp_pkg::KIND_LOAD, 0, 0, a, v);
            end else begin
                case ($urandom_range(0, 19))
                    0, 1: begin
                        x = int'($urandom_range(0, 1023)) - 512;
                        y = int'($urandom_range(0, 1023)) - 512;
                    end
                    2: begin
                        x = ($urandom_range(0, 1) != 0) ? mw : -1;
                        y = $urandom_range(0, mh);
                    end
                    3, 4, 5, 6: begin
                        x = $urandom_range(0, mw - 1);
                        y = $urandom_range(0, mh - 1);
                    end
                    default: begin
                        x = ax + int'($urandom_range(0, 4)) - 2;
                        y = ay + int'($urandom_range(0, 4)) - 2;
                    end
                endcase
                queue_stroke(bsp_pkg::KIND_READ, x, y, 0, 0);
            end
            n = strokes_queued - base;   // count what this phase has queued
        end
    endtask

    // Register settings per phase: mode, rate, map width, map height, brush width, height.
    // Zero and oversized values check the clamps; the unused mode must leave cells alone.
    int setting_plan [N_SETTINGS][6];
    int phase_items  [N_SETTINGS] = '{70, 70, 20, 60, 50, 45, 50, 70, 80};

    initial begin
        setting_plan = '{
            '{int'(bsp_pkg::MODE_LIGHTEN), 0,  256, 256, 3,  3},
            '{int'(bsp_pkg::MODE_DARKEN),  19, 16,  16,  5,  4},
            '{int'(bsp_pkg::MODE_PAINT),   10, 256, 256, 32, 32},
            '{int'(bsp_pkg::MODE_HOLD),    7,  40,  30,  4,  4},
            '{int'(bsp_pkg::MODE_LIGHTEN), 31, 0,   511, 0,  63},
            '{int'(bsp_pkg::MODE_DARKEN),  1,  1,   1,   2,  2},
            '{int'(bsp_pkg::MODE_PAINT),   19, 511, 0,   7,  9},
            '{int'(bsp_pkg::MODE_LIGHTEN), 5,  100, 256, 1,  1},
            '{int'(bsp_pkg::MODE_DARKEN),  12, 256, 256, 6,  6}
        };

        // Shadow state after reset
        for (int i = 0; i < bsp_pkg::MAP_CELLS; i++)
            shade_mem[bsp_pkg::MAP_AW'(i)] = bsp_pkg::SHADE_CLEAR;
        for (int i = 0; i < bsp_pkg::BRUSH_CELLS; i++)
            brush_mem[bsp_pkg::BRUSH_AW'(i)] = '0;
        last_cx     = -1;
        last_cy     = -1;
        mode_reg    = bsp_pkg::MODE_PAINT;
        rate_reg    = '0;
        map_w_reg   = 9'(bsp_pkg::MAP_SIDE_MAX);
        map_h_reg   = 9'(bsp_pkg::MAP_SIDE_MAX);
        brush_w_reg = 6'd1;
        brush_h_reg = 6'd1;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // Wait out the clearing sweep
        do @(negedge i_clk);
        while (!o_ready);

        // Directed opening under the reset settings: cleared map, edges, outside reads,
        // stamp at the cleared cursor, repeated cursor, pen-up, off-map cursors.
        queue_stroke(bsp_pkg::KIND_READ, 0, 0, 0, 0);
        queue_stroke(bsp_pkg::KIND_READ, 255, 255, 0, 0);
        queue_stroke(bsp_pkg::KIND_READ, 256, 0, 0, 0);
        queue_stroke(bsp_pkg::KIND_READ, -1, 5, 0, 0);
        queue_stroke(bsp_pkg::KIND_READ, -512, 511, 0, 0);
        queue_stroke(bsp_pkg::KIND_LOAD, 0, 0, 0, 255);
        queue_stroke(bsp_pkg::KIND_LOAD, 0, 0, 1023, 170);
        queue_stroke(bsp_pkg::KIND_LOAD, 0, 0, 512, 85);
        queue_stroke(bsp_pkg::KIND_PAINT, -1, -1, 0, 0);
        queue_stroke(bsp_pkg::KIND_PAINT, 5, 5, 0, 0);
        queue_stroke(bsp_pkg::KIND_READ, 5, 5, 0, 0);
        queue_stroke(bsp_pkg::KIND_PAINT, 5, 5, 0, 0);
        queue_stroke(bsp_pkg::KIND_PENUP, 0, 0, 0, 0);
        queue_stroke(bsp_pkg::KIND_LOAD, 0, 0, 0, 1);
        queue_stroke(bsp_pkg::KIND_PAINT, 5, 5, 0, 0);
        queue_stroke(bsp_pkg::KIND_READ, 5, 5, 0, 0);
        queue_stroke(bsp_pkg::KIND_PAINT, 511, -512, 0, 0);
        queue_stroke(bsp_pkg::KIND_PAINT, -512, 511, 0, 0);
        queue_stroke(bsp_pkg::KIND_READ, 0, 255, 0, 0);

        for (int p = 0; p < N_SETTINGS; p++) begin
            // Pause the sender until every result is back, then reprogram
            wait_drained();
            apply_setting(setting_plan[p][0], setting_plan[p][1], setting_plan[p][2],
                          setting_plan[p][3], setting_plan[p][4], setting_plan[p][5]);
            if (p == 0) begin
                // A 3x3 brush reaches (0,0) from the cleared cursor, so a skipped stamp shows
                queue_stroke(bsp_pkg::KIND_LOAD, 0, 0, 8, 200);
                queue_stroke(bsp_pkg::KIND_PENUP, 0, 0, 0, 0);
                queue_stroke(bsp_pkg::KIND_PAINT, -1, -1, 0, 0);
                queue_stroke(bsp_pkg::KIND_READ, 0, 0, 0, 0);
            end
            // Last phase runs flat out on both sides
            if (p == N_SETTINGS - 1)
                calm = 1'b1;
            queue_random_phase(phase_items[p]);
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Checked %0d transactions: %0d loads, %0d stamps (%0d applied), %s",
                 results_seen, kind_tally[bsp_pkg::KIND_LOAD], kind_tally[bsp_pkg::KIND_PAINT],
                 stamps_applied, "plus pen-ups and reads below");
        $display("Pen-ups %0d, reads %0d, register settings visited %0d, %s",
                 kind_tally[bsp_pkg::KIND_PENUP], kind_tally[bsp_pkg::KIND_READ],
                 N_SETTINGS + 1, "including clamped sizes and the unused mode");
        if (mismatches == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
